### hw/rtl/stick_adc_average_and_map_macros.svh
// Assertion helpers for the stick ADC average block.
`ifndef STICK_ADC_AVERAGE_AND_MAP_MACROS_SVH
`define STICK_ADC_AVERAGE_AND_MAP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SAAM_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the following cycle.
`define SAAM_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/saam_pkg.sv
package saam_pkg;

  // Channel map and window
  localparam int WINDOW_SAMPLES  = 16;
  localparam int CHANNEL_COUNT   = 5;
  localparam int THRUST_CHANNEL  = 0;
  localparam int YAW_CHANNEL     = 1;
  localparam int BATTERY_CHANNEL = 4;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int CHANNEL_W  = 3;
  localparam int KIND_W     = 2;
  localparam int MV_W       = 14;
  localparam int PCT_W      = 7;
  localparam int GAIN_W     = 12;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Ring storage
  localparam int RING_DEPTH = CHANNEL_COUNT * WINDOW_SAMPLES;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PTR_W      = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int CH_IDX_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_SAMPLES);

  // Stream packing
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = CHANNEL_W;
  localparam int MEAN_LSB   = 0;
  localparam int STICK_LSB  = MEAN_LSB + SAMPLE_W;
  localparam int MV_LSB     = STICK_LSB + SAMPLE_W;
  localparam int PCT_LSB    = MV_LSB + MV_W;
  localparam int M_FIELDS_W = PCT_LSB + PCT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int KIND_LSB   = CHANNEL_W;
  localparam int M_TUSER_W  = CHANNEL_W + KIND_W;

  typedef logic [KIND_W-1:0] kind_t;

  // Result kinds
  localparam kind_t KIND_THRUST  = 2'd0;
  localparam kind_t KIND_YAW     = 2'd1;
  localparam kind_t KIND_BATTERY = 2'd2;
  localparam kind_t KIND_OTHER   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_CENTER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_SCALE = 3'd5;

  // Register reset values
  localparam int RST_CENTER = 2048;
  localparam int RST_OFFSET = 0;
  localparam int RST_GAIN   = 256;
  localparam int RST_SCALE  = 1600;

  // Stick mapping: 1500 + floor(c * gain * 1000 / 2^20)
  localparam int GAIN_UNITY  = 256;
  localparam int STICK_SCALE = 1000;
  localparam int STICK_SHIFT = 20;
  localparam int STICK_BIAS  = 1500;
  localparam int STICK_MAX   = 4095;

  // Battery: floor(uV / 1000) by reciprocal, exact for uV below 2^28
  localparam int UV_W      = SAMPLE_W + SCALE_W;
  localparam int MV_RECIP  = 274877907;
  localparam int MV_SHIFT  = 38;
  localparam int MV_PROD_W = UV_W + 29;
  localparam int MV_Q_W    = MV_PROD_W - MV_SHIFT;
  localparam int MV_MAX    = 16383;

  // Percent: floor((uV - 3650000) / 5500), exact for differences below 2^20
  localparam int PCT_LO_UV  = 3650000;
  localparam int PCT_HI_UV  = 4194500;
  localparam int PCT_RECIP  = 1561807;
  localparam int PCT_SHIFT  = 33;
  localparam int DIFF_W     = 20;
  localparam int PCT_PROD_W = DIFF_W + 21;
  localparam int PCT_MAX    = 99;

endpackage

### hw/rtl/stick_adc_average_and_map.sv
// Per-channel moving average of ADC samples with stick and battery scaling.
// One word in s_tdata/s_tuser is accepted per clock while s_tready is high, and
// the matching result passes stage registers A, B, C and D to register O and then
// m_tdata/m_tuser; the sustained rate is one word per cycle while m_tready is high,
// set by the simple dual-port ring RAM (80 entries, one read and one write per
// cycle) and a five-register pipeline that absorbs bubbles, so s_tready only
// drops when every stage holds a word and the output is stalled. The ring read
// is forwarded from the write of the word ahead, and per-entry valid bits make
// never-written entries read as zero, so no clearing pass is needed after
// reset. Registers on the cfg port may only be written while no word is in flight.
module stick_adc_average_and_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [saam_pkg::S_TDATA_W-1:0]   s_tdata,   // sample
  input  logic [saam_pkg::S_TUSER_W-1:0]   s_tuser,   // channel
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [saam_pkg::M_TDATA_W-1:0]   m_tdata,   // mean, stick_command, battery_mv,
                                                      // battery_percent, zero pad
  output logic [saam_pkg::M_TUSER_W-1:0]   m_tuser,   // channel_out, command_kind
  input  logic                             cfg_wen,
  input  logic [saam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [saam_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import saam_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0] thrust_center, yaw_center, thrust_offset, yaw_offset;
  logic [GAIN_W-1:0]   thrust_gain;
  logic [SCALE_W-1:0]  battery_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_center <= SAMPLE_W'(RST_CENTER);
      yaw_center    <= SAMPLE_W'(RST_CENTER);
      thrust_offset <= SAMPLE_W'(RST_OFFSET);
      yaw_offset    <= SAMPLE_W'(RST_OFFSET);
      thrust_gain   <= GAIN_W'(RST_GAIN);
      battery_scale <= SCALE_W'(RST_SCALE);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_THRUST_CENTER: thrust_center <= cfg_wdata[SAMPLE_W-1:0];
        REG_YAW_CENTER:    yaw_center    <= cfg_wdata[SAMPLE_W-1:0];
        REG_THRUST_OFFSET: thrust_offset <= cfg_wdata[SAMPLE_W-1:0];
        REG_YAW_OFFSET:    yaw_offset    <= cfg_wdata[SAMPLE_W-1:0];
        REG_THRUST_GAIN:   thrust_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_BATTERY_SCALE: battery_scale <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and load enables, bubbles collapse
  logic a_valid, b_valid, c_valid, d_valid, o_valid;
  logic ld_a, ld_b, ld_c, ld_d, ld_o;
  logic s_fire, a_fire;

  assign ld_o     = !o_valid || m_tready;
  assign ld_d     = !d_valid || ld_o;
  assign ld_c     = !c_valid || ld_d;
  assign ld_b     = !b_valid || ld_c;
  assign ld_a     = !a_valid || ld_b;
  assign s_tready = ld_a;
  assign s_fire   = s_tvalid && ld_a;
  assign a_fire   = a_valid && ld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (ld_a) a_valid <= s_tvalid;
      if (ld_b) b_valid <= a_valid;
      if (ld_c) c_valid <= b_valid;
      if (ld_d) d_valid <= c_valid;
      if (ld_o) o_valid <= d_valid;
    end
  end

  // ---------------- accept: pointer lookup and ring read ----------------
  logic [SAMPLE_W-1:0] in_sample;
  logic [CHANNEL_W-1:0] in_ch;
  logic [CH_IDX_W-1:0] in_idx;
  logic                in_range;
  logic [RING_AW-1:0]  rd_pos;

  logic [PTR_W-1:0]    ring_ptr [CHANNEL_COUNT];
  logic [SUM_W-1:0]    ch_sum   [CHANNEL_COUNT];
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;

  assign in_sample = s_tdata[SAMPLE_W-1:0];
  assign in_ch     = s_tuser;
  assign in_idx    = in_ch[CH_IDX_W-1:0];
  assign in_range  = int'(in_ch) < CHANNEL_COUNT;
  assign rd_pos    = RING_AW'(int'(in_idx) * WINDOW_SAMPLES + int'(ring_ptr[in_idx]));

  // stage A registers
  logic [SAMPLE_W-1:0]  a_sample, a_rd, a_fwd_data;
  logic [CHANNEL_W-1:0] a_ch;
  logic [CH_IDX_W-1:0]  a_idx;
  logic                 a_range, a_old_vld, a_fwd;
  logic [RING_AW-1:0]   a_pos;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_sample   <= in_sample;
      a_ch       <= in_ch;
      a_idx      <= in_idx;
      a_range    <= in_range;
      a_pos      <= rd_pos;
      a_old_vld  <= ring_vld[rd_pos];
      // the word ahead writes this slot on the same edge
      a_fwd      <= a_fire && a_range && (a_pos == rd_pos);
      a_fwd_data <= a_sample;
    end
  end

  // ring RAM: one write from stage A, one registered read at accept
  always_ff @(posedge clk) begin
    if (a_fire && a_range) ring_mem[a_pos] <= a_sample;
    if (s_fire && in_range) a_rd <= ring_mem[rd_pos];
  end

  // ---------------- stage A: sum update and mean ----------------
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum_new;
  logic [SAMPLE_W-1:0] mean_new;
  kind_t               a_kind;

  always_comb begin
    old_sample = a_fwd ? a_fwd_data : (a_old_vld ? a_rd : '0);
    sum_new    = ch_sum[a_idx] - SUM_W'(old_sample) + SUM_W'(a_sample);
    mean_new   = SAMPLE_W'(sum_new / WINDOW_SAMPLES);
    if (!a_range)                             a_kind = KIND_OTHER;
    else if (int'(a_ch) == THRUST_CHANNEL)    a_kind = KIND_THRUST;
    else if (int'(a_ch) == YAW_CHANNEL)       a_kind = KIND_YAW;
    else if (int'(a_ch) == BATTERY_CHANNEL)   a_kind = KIND_BATTERY;
    else                                      a_kind = KIND_OTHER;
  end

  // valid bits, pointers and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ring_ptr[i] <= '0;
        ch_sum[i]   <= '0;
      end
    end else begin
      if (s_fire && in_range) begin
        ring_ptr[in_idx] <= (ring_ptr[in_idx] == PTR_W'(WINDOW_SAMPLES - 1)) ?
                            '0 : ring_ptr[in_idx] + 1'b1;
      end
      if (a_fire && a_range) begin
        ring_vld[a_pos] <= 1'b1;
        ch_sum[a_idx]   <= sum_new;
      end
    end
  end

  logic [CHANNEL_W-1:0] b_ch;
  logic [SAMPLE_W-1:0]  b_mean;
  kind_t                b_kind;

  always_ff @(posedge clk) begin
    if (ld_b) begin
      b_ch   <= a_ch;
      b_kind <= a_kind;
      b_mean <= a_range ? mean_new : '0;
    end
  end

  // ---------------- stage B: offset, clamp, center, gain; battery uV ----------------
  logic                     b_thrust;
  logic [SAMPLE_W-1:0]      b_off, b_ctr;
  logic signed [13:0]       v_raw, v_clamp, v_cent;
  logic [13:0]              gain_sel;
  logic signed [27:0]       prod1;
  logic [UV_W-1:0]          uv;

  always_comb begin
    b_thrust = (b_kind == KIND_THRUST);
    b_off    = b_thrust ? thrust_offset : yaw_offset;
    b_ctr    = b_thrust ? thrust_center : yaw_center;
    // mean below 4096, so only the low clamp can bite
    v_raw    = $signed({2'b00, b_mean}) - $signed({2'b00, b_off});
    v_clamp  = (v_raw < 0) ? '0 : v_raw;
    v_cent   = v_clamp - $signed({2'b00, b_ctr});
    gain_sel = b_thrust ? 14'(thrust_gain) : 14'(GAIN_UNITY);
    prod1    = 28'(v_cent) * $signed(28'(gain_sel));
    uv       = UV_W'(b_mean) * UV_W'(battery_scale);
  end

  logic [CHANNEL_W-1:0] c_ch;
  logic [SAMPLE_W-1:0]  c_mean;
  kind_t                c_kind;
  logic signed [27:0]   c_prod1;
  logic [UV_W-1:0]      c_uv;

  always_ff @(posedge clk) begin
    if (ld_c) begin
      c_ch    <= b_ch;
      c_kind  <= b_kind;
      c_mean  <= b_mean;
      c_prod1 <= prod1;
      c_uv    <= uv;
    end
  end

  // ---------------- stage C: constant scaling and reciprocal products ----------------
  logic signed [37:0]     prod2;
  logic [MV_PROD_W-1:0]   mv_prod;
  logic [DIFF_W-1:0]      pct_diff;
  logic [PCT_PROD_W-1:0]  pct_prod;

  always_comb begin
    prod2    = 38'(c_prod1) * 38'(STICK_SCALE);
    mv_prod  = MV_PROD_W'(c_uv) * MV_PROD_W'(MV_RECIP);
    pct_diff = DIFF_W'(c_uv - UV_W'(PCT_LO_UV));
    pct_prod = PCT_PROD_W'(pct_diff) * PCT_PROD_W'(PCT_RECIP);
  end

  logic [CHANNEL_W-1:0] d_ch;
  logic [SAMPLE_W-1:0]  d_mean;
  kind_t                d_kind;
  logic signed [37:0]   d_prod2;
  logic [MV_Q_W-1:0]    d_mv_q;
  logic [PCT_W-1:0]     d_pct_q;
  logic                 d_pct_lo, d_pct_hi;

  always_ff @(posedge clk) begin
    if (ld_d) begin
      d_ch     <= c_ch;
      d_kind   <= c_kind;
      d_mean   <= c_mean;
      d_prod2  <= prod2;
      d_mv_q   <= mv_prod[MV_PROD_W-1:MV_SHIFT];
      d_pct_q  <= pct_prod[PCT_SHIFT+PCT_W-1:PCT_SHIFT];
      d_pct_lo <= c_uv < UV_W'(PCT_LO_UV);
      d_pct_hi <= c_uv >= UV_W'(PCT_HI_UV);
    end
  end

  // ---------------- stage D: bias, saturation, field selection ----------------
  logic signed [17:0]   stick_q;
  logic signed [18:0]   stick_sum;
  logic [SAMPLE_W-1:0]  stick_sat;
  logic [MV_W-1:0]      mv_sat;
  logic [PCT_W-1:0]     pct_sat;
  logic                 d_stick_kind, d_batt_kind;

  always_comb begin
    stick_q   = 18'(d_prod2 >>> STICK_SHIFT);
    stick_sum = 19'(stick_q) + 19'(STICK_BIAS);
    if (stick_sum < 0)                   stick_sat = '0;
    else if (stick_sum > 19'(STICK_MAX)) stick_sat = SAMPLE_W'(STICK_MAX);
    else                                 stick_sat = stick_sum[SAMPLE_W-1:0];
    mv_sat  = (d_mv_q > MV_Q_W'(MV_MAX)) ? MV_W'(MV_MAX) : d_mv_q[MV_W-1:0];
    if (d_pct_lo)      pct_sat = '0;
    else if (d_pct_hi) pct_sat = PCT_W'(PCT_MAX);
    else               pct_sat = d_pct_q;
    d_stick_kind = (d_kind == KIND_THRUST) || (d_kind == KIND_YAW);
    d_batt_kind  = (d_kind == KIND_BATTERY);
  end

  logic [CHANNEL_W-1:0] o_ch;
  logic [SAMPLE_W-1:0]  o_mean, o_stick;
  kind_t                o_kind;
  logic [MV_W-1:0]      o_mv;
  logic [PCT_W-1:0]     o_pct;

  always_ff @(posedge clk) begin
    if (ld_o) begin
      o_ch    <= d_ch;
      o_kind  <= d_kind;
      o_mean  <= d_mean;
      o_stick <= d_stick_kind ? stick_sat : '0;
      o_mv    <= d_batt_kind ? mv_sat : '0;
      o_pct   <= d_batt_kind ? pct_sat : '0;
    end
  end

  // output word
  assign m_tvalid = o_valid;
  assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), o_pct, o_mv, o_stick, o_mean};
  assign m_tuser  = {o_kind, o_ch};

endmodule

### hw/rtl/saam_checker.sv
`include "stick_adc_average_and_map_macros.svh"

// Port-level checks for the stick ADC average block.
module saam_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [saam_pkg::S_TDATA_W-1:0]   s_tdata,
  input logic [saam_pkg::S_TUSER_W-1:0]   s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [saam_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic [saam_pkg::M_TUSER_W-1:0]   m_tuser,
  input logic                             cfg_wen,
  input logic [saam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [saam_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import saam_pkg::*;

  logic [CHANNEL_W-1:0] chk_ch;
  kind_t                chk_kind;
  logic [SAMPLE_W-1:0]  chk_mean, chk_stick;
  logic [MV_W-1:0]      chk_mv;
  logic [PCT_W-1:0]     chk_pct;

  assign chk_ch    = m_tuser[CHANNEL_W-1:0];
  assign chk_kind  = m_tuser[KIND_LSB+KIND_W-1:KIND_LSB];
  assign chk_mean  = m_tdata[MEAN_LSB+SAMPLE_W-1:MEAN_LSB];
  assign chk_stick = m_tdata[STICK_LSB+SAMPLE_W-1:STICK_LSB];
  assign chk_mv    = m_tdata[MV_LSB+MV_W-1:MV_LSB];
  assign chk_pct   = m_tdata[PCT_LSB+PCT_W-1:PCT_LSB];

  // a stalled result word holds
  `SAAM_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

  // unknown channels carry nothing
  `SAAM_IMPLIES(a_bad_chan, m_tvalid && (int'(chk_ch) >= CHANNEL_COUNT), (chk_kind == KIND_OTHER) && (chk_mean == '0), "out-of-range channel not reported empty")

  // battery fields only for the battery kind, percent capped
  `SAAM_IMPLIES(a_batt_fields, m_tvalid, (chk_pct <= PCT_W'(PCT_MAX)) && ((chk_kind == KIND_BATTERY) || ((chk_mv == '0) && (chk_pct == '0))), "battery fields wrong for kind")

  // stick command only for thrust and yaw
  `SAAM_IMPLIES(a_stick_kind, m_tvalid && (chk_kind != KIND_THRUST) && (chk_kind != KIND_YAW), chk_stick == '0, "stick command set for non-stick kind")

  // thrust kind comes only from the thrust channel
  `SAAM_IMPLIES(a_thrust_chan, m_tvalid && (chk_kind == KIND_THRUST), int'(chk_ch) == THRUST_CHANNEL, "thrust kind on wrong channel")

endmodule

bind stick_adc_average_and_map saam_checker u_saam_checker (.*);
